FILE: rtl/core/ist_pkg.sv
// Shared types, codes and defaults for the interval set table.
package ist_pkg;

    localparam int unsigned DEF_MAX_RANGES  = 16;
    localparam int unsigned DEF_OFFSET_BITS = 63;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SCAN   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_BAD_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        KIND_NONE          = 3'd0,
        KIND_EQUAL         = 3'd1,
        KIND_CONTAINS      = 3'd2,
        KIND_CONTAINED     = 3'd3,
        KIND_STARTS_BEFORE = 3'd4,
        KIND_ENDS_AFTER    = 3'd5
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic eval;
        logic second;
        logic flush;
        logic finish;
    } t_dp_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip_walk;
        logic need_second;
        logic last;
        logic walk_done;
    } t_dp_sts;

endpackage

FILE: rtl/core/ist_ram.sv
// Generic simple dual-port RAM with registered read.
module ist_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ist_dp.sv
// Datapath: table banks, range evaluation, merge/trim logic and result registers.
module ist_dp import ist_pkg::*; #(
    parameter int unsigned MAX_RANGES  = DEF_MAX_RANGES,
    parameter int unsigned OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_dp_ctl                           i_ctl,
    output t_dp_sts                           o_sts,
    input  logic [1:0]                        i_cmd,
    input  logic [OFFSET_BITS-1:0]            i_range_start,
    input  logic [OFFSET_BITS-1:0]            i_range_end,
    input  logic                              i_end_open,
    output logic [1:0]                        o_status,
    output logic [2:0]                        o_overlap_kind,
    output logic [$clog2(MAX_RANGES+1)-1:0]   o_overlap_position,
    output logic [OFFSET_BITS-1:0]            o_found_start,
    output logic [OFFSET_BITS-1:0]            o_found_end,
    output logic                              o_found_end_open,
    output logic [$clog2(MAX_RANGES+1)-1:0]   o_entry_count
);

    localparam int unsigned IDX_W     = $clog2(MAX_RANGES);
    localparam int unsigned CNT_W     = $clog2(MAX_RANGES + 1);
    localparam int unsigned ENT_W     = 2 * OFFSET_BITS + 1;
    localparam int unsigned RAM_DEPTH = 2 ** (IDX_W + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RANGES);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [OFFSET_BITS:0] WIDE_ONE = (OFFSET_BITS + 1)'(1);
    localparam logic [OFFSET_BITS-1:0] OFS_ONE = OFFSET_BITS'(1);

    typedef logic [OFFSET_BITS-1:0] t_ofs;

    // control state
    logic             r_bank, n_bank;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_widx, n_widx;
    t_cmd             r_op, n_op;

    // command payload and walk accumulators
    t_ofs  r_s, n_s, r_e, n_e;
    logic  r_eo, n_eo, r_bad, n_bad;
    t_ofs  r_ps, n_ps, r_pe, n_pe;
    logic  r_po, n_po, r_placed, n_placed;
    logic  r_hit, n_hit, r_split, n_split;
    t_ofs  r_sec_s, n_sec_s, r_sec_e, n_sec_e;
    logic  r_sec_o, n_sec_o;
    logic  r_found, n_found;
    t_kind r_kind, n_kind;
    logic [CNT_W-1:0] r_pos, n_pos;
    t_ofs  r_fs, n_fs, r_fe, n_fe;
    logic  r_fo, n_fo;

    // result registers
    t_status          r_o_status, n_o_status;
    t_kind            r_o_kind, n_o_kind;
    logic [CNT_W-1:0] r_o_pos, n_o_pos, r_o_count, n_o_count;
    t_ofs             r_o_fs, n_o_fs, r_o_fe, n_o_fe;
    logic             r_o_fo, n_o_fo;

    // memory ports
    logic [ENT_W-1:0]   rd_data, wr_data;
    logic [IDX_W:0]     rd_addr, wr_addr;
    logic               wr_req, wr_go;
    t_ofs               wr_s, wr_e;
    logic               wr_o;

    // current entry
    t_ofs x_s, x_e;
    logic x_o;
    logic skip, none_stop, ovl, x_before, p_before, head, tail;
    t_kind cls;
    t_status st;

    assign x_s = rd_data[OFFSET_BITS-1:0];
    assign x_e = rd_data[2*OFFSET_BITS-1:OFFSET_BITS];
    assign x_o = rd_data[2*OFFSET_BITS];

    always_comb begin
        skip      = !x_o && (r_s > x_e);
        none_stop = !r_eo && (x_s > r_e);
        ovl       = !skip && !none_stop;
        x_before  = !x_o && (({1'b0, x_e} + WIDE_ONE) < {1'b0, r_ps});
        p_before  = !r_po && (({1'b0, r_pe} + WIDE_ONE) < {1'b0, x_s});
        head      = x_s < r_s;
        tail      = !r_eo && !(&r_e) && (x_o || (x_e > r_e));

        if (x_s == r_s && x_o == r_eo && (x_o || x_e == r_e)) begin
            cls = KIND_EQUAL;
        end else if (x_s <= r_s && !r_eo && (x_o || x_e >= r_e)) begin
            cls = KIND_CONTAINS;
        end else if (r_s <= x_s && (r_eo || (!x_o && r_e >= x_e))) begin
            cls = KIND_CONTAINED;
        end else if (x_s < r_s) begin
            cls = KIND_STARTS_BEFORE;
        end else begin
            cls = KIND_ENDS_AFTER;
        end
    end

    always_comb begin
        o_sts.skip_walk   = (r_op == CMD_CLEAR) || r_bad || (r_count == '0);
        o_sts.need_second = ((r_op == CMD_ADD) && !r_placed && !x_before && p_before)
                          || ((r_op == CMD_REMOVE) && ovl && head && tail);
        o_sts.last        = (r_idx + CNT_ONE) == r_count;
        o_sts.walk_done   = r_idx == r_count;
    end

    always_comb begin
        n_bank = r_bank;   n_count = r_count; n_idx = r_idx;   n_widx = r_widx;
        n_op = r_op;       n_s = r_s;         n_e = r_e;       n_eo = r_eo;
        n_bad = r_bad;     n_ps = r_ps;       n_pe = r_pe;     n_po = r_po;
        n_placed = r_placed; n_hit = r_hit;   n_split = r_split;
        n_sec_s = r_sec_s; n_sec_e = r_sec_e; n_sec_o = r_sec_o;
        n_found = r_found; n_kind = r_kind;   n_pos = r_pos;
        n_fs = r_fs;       n_fe = r_fe;       n_fo = r_fo;
        n_o_status = r_o_status; n_o_kind = r_o_kind; n_o_pos = r_o_pos;
        n_o_fs = r_o_fs;   n_o_fe = r_o_fe;   n_o_fo = r_o_fo; n_o_count = r_o_count;
        wr_req = 1'b0;     wr_s = x_s;        wr_e = x_e;      wr_o = x_o;
        st = STAT_DONE;

        if (i_ctl.load) begin
            n_op     = t_cmd'(i_cmd);
            n_s      = i_range_start;
            n_e      = i_range_end;
            n_eo     = i_end_open;
            n_bad    = !i_end_open && (i_range_end < i_range_start);
            n_idx    = '0;
            n_widx   = '0;
            n_ps     = i_range_start;
            n_pe     = i_range_end;
            n_po     = i_end_open;
            n_placed = 1'b0;
            n_hit    = 1'b0;
            n_split  = 1'b0;
            n_found  = 1'b0;
            n_kind   = KIND_NONE;
            n_pos    = '0;
            n_fs     = '0;
            n_fe     = '0;
            n_fo     = 1'b0;
        end

        if (i_ctl.eval) begin
            n_idx = r_idx + CNT_ONE;
            case (r_op)
                CMD_ADD: begin
                    if (ovl) begin
                        n_hit = 1'b1;
                    end
                    if (r_placed || x_before) begin
                        wr_req = 1'b1;
                    end else if (p_before) begin
                        // pending range lands ahead of this entry; entry follows next cycle
                        wr_req   = 1'b1;
                        wr_s     = r_ps;
                        wr_e     = r_pe;
                        wr_o     = r_po;
                        n_sec_s  = x_s;
                        n_sec_e  = x_e;
                        n_sec_o  = x_o;
                        n_placed = 1'b1;
                    end else begin
                        // coalesce: smaller start, larger end, open wins
                        n_ps = (x_s < r_ps) ? x_s : r_ps;
                        n_po = r_po || x_o;
                        n_pe = (x_e > r_pe) ? x_e : r_pe;
                    end
                end
                CMD_REMOVE: begin
                    if (!ovl) begin
                        wr_req = 1'b1;
                    end else if (head) begin
                        wr_req = 1'b1;
                        wr_s   = x_s;
                        wr_e   = r_s - OFS_ONE;
                        wr_o   = 1'b0;
                        if (tail) begin
                            n_sec_s = r_e + OFS_ONE;
                            n_sec_e = x_e;
                            n_sec_o = x_o;
                            n_split = 1'b1;
                        end
                    end else if (tail) begin
                        wr_req = 1'b1;
                        wr_s   = r_e + OFS_ONE;
                    end
                end
                CMD_SCAN: begin
                    if (!r_found && !skip) begin
                        n_found = 1'b1;
                        n_pos   = r_idx;
                        if (none_stop) begin
                            n_kind = KIND_NONE;
                        end else begin
                            n_kind = cls;
                            n_fs   = x_s;
                            n_fe   = x_o ? '0 : x_e;
                            n_fo   = x_o;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (i_ctl.second) begin
            wr_req = 1'b1;
            wr_s   = r_sec_s;
            wr_e   = r_sec_e;
            wr_o   = r_sec_o;
        end

        if (i_ctl.flush && (r_op == CMD_ADD) && !r_bad && !r_placed) begin
            wr_req = 1'b1;
            wr_s   = r_ps;
            wr_e   = r_pe;
            wr_o   = r_po;
        end

        if (wr_go) begin
            n_widx = r_widx + CNT_ONE;
        end

        if (i_ctl.finish) begin
            if (r_op != CMD_CLEAR && r_bad) begin
                st = STAT_BAD_RANGE;
            end else if (r_op == CMD_ADD && r_count == CNT_MAX && !r_hit) begin
                st = STAT_FULL;
            end else if (r_op == CMD_REMOVE && r_split && r_count == CNT_MAX) begin
                st = STAT_FULL;
            end

            // commit: on a successful add or remove, swap to the rebuilt bank; clear zeroes the count
            if (r_op == CMD_CLEAR) begin
                n_count = '0;
            end else if (st == STAT_DONE && (r_op == CMD_ADD || r_op == CMD_REMOVE)) begin
                n_count = r_widx;
                n_bank  = ~r_bank;
            end

            n_o_status = st;
            n_o_count  = n_count;
            n_o_kind   = KIND_NONE;
            n_o_pos    = '0;
            n_o_fs     = '0;
            n_o_fe     = '0;
            n_o_fo     = 1'b0;
            if (r_op == CMD_SCAN && !r_bad) begin
                if (r_found) begin
                    n_o_kind = r_kind;
                    n_o_pos  = r_pos;
                    n_o_fs   = r_fs;
                    n_o_fe   = r_fe;
                    n_o_fo   = r_fo;
                end else begin
                    n_o_pos  = r_count;
                end
            end
        end
    end

    assign wr_go   = wr_req && (r_widx != CNT_MAX);
    assign wr_data = {wr_o, (wr_o ? '0 : wr_e), wr_s};
    assign rd_addr = {r_bank, n_idx[IDX_W-1:0]};
    assign wr_addr = {~r_bank, r_widx[IDX_W-1:0]};

    ist_ram #(
        .WIDTH (ENT_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_go),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank  <= 1'b0;
            r_count <= '0;
            r_idx   <= '0;
            r_widx  <= '0;
            r_op    <= CMD_SCAN;
        end else begin
            r_bank  <= n_bank;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_widx  <= n_widx;
            r_op    <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;           r_e <= n_e;           r_eo <= n_eo;     r_bad <= n_bad;
        r_ps <= n_ps;         r_pe <= n_pe;         r_po <= n_po;     r_placed <= n_placed;
        r_hit <= n_hit;       r_split <= n_split;
        r_sec_s <= n_sec_s;   r_sec_e <= n_sec_e;   r_sec_o <= n_sec_o;
        r_found <= n_found;   r_kind <= n_kind;     r_pos <= n_pos;
        r_fs <= n_fs;         r_fe <= n_fe;         r_fo <= n_fo;
        r_o_status <= n_o_status; r_o_kind <= n_o_kind; r_o_pos <= n_o_pos;
        r_o_fs <= n_o_fs;     r_o_fe <= n_o_fe;     r_o_fo <= n_o_fo;
        r_o_count <= n_o_count;
    end

    assign o_status           = r_o_status;
    assign o_overlap_kind     = r_o_kind;
    assign o_overlap_position = r_o_pos;
    assign o_found_start      = r_o_fs;
    assign o_found_end        = r_o_fe;
    assign o_found_end_open   = r_o_fo;
    assign o_entry_count      = r_o_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("held count above table size");

    a_write_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_op == CMD_ADD || r_op == CMD_REMOVE)
        |-> ({1'b0, r_widx} <= ({1'b0, r_idx} + (CNT_W + 1)'(1))))
        else $error("rebuilt bank grew faster than the walk");

    a_scan_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.finish && r_op == CMD_SCAN)
        |=> (r_count == $past(r_count) && r_bank == $past(r_bank)))
        else $error("scan changed the table");

endmodule

FILE: rtl/core/ist_ctrl.sv
// Controller: sequences load, table walk, flush and result transfer.
module ist_ctrl import ist_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    input  t_dp_sts i_sts,
    output t_dp_ctl o_ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WALK,
        S_SECOND,
        S_FLUSH,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                n_state = i_sts.skip_walk ? S_FLUSH : S_WALK;
            end
            S_WALK: begin
                o_ctl.eval = 1'b1;
                if (i_sts.need_second) begin
                    n_state = S_SECOND;
                end else if (i_sts.last) begin
                    n_state = S_FLUSH;
                end
            end
            S_SECOND: begin
                o_ctl.second = 1'b1;
                n_state = i_sts.walk_done ? S_FLUSH : S_WALK;
            end
            S_FLUSH: begin
                o_ctl.flush = 1'b1;
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    o_ctl.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_ctl.finish || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/core/interval_set_table_unit.sv
// Top level of the interval set table: controller plus datapath.
//
// Keeps a sorted table of up to MAX_RANGES disjoint, inclusive offset ranges, any of
// which may be open ended. Each command (add, remove, scan, clear) gives exactly one
// result. The table lives in two banks of one RAM: add and remove stream the current
// bank one entry per cycle, pausing for an extra write when a new range is slotted in
// ahead of an existing entry or an entry is split in two, and write the rebuilt list
// into the other bank, then swap banks when the command succeeds, so a dropped command
// (table full or end below start) leaves the table untouched. Clear and rejected
// commands skip the walk. The walk is bounded by the single RAM read port. A new
// command is taken only while the unit is idle, but a finished result may still wait
// at the output while the next command is transferred in. There is no clearing pass
// after reset: the held count starts at zero and only entries below it are ever read.
module interval_set_table_unit import ist_pkg::*; #(
    parameter int unsigned MAX_RANGES  = DEF_MAX_RANGES,
    parameter int unsigned OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_cmd,
    input  logic [OFFSET_BITS-1:0]          i_range_start,
    input  logic [OFFSET_BITS-1:0]          i_range_end,
    input  logic                            i_end_open,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_status,
    output logic [2:0]                      o_overlap_kind,
    output logic [$clog2(MAX_RANGES+1)-1:0] o_overlap_position,
    output logic [OFFSET_BITS-1:0]          o_found_start,
    output logic [OFFSET_BITS-1:0]          o_found_end,
    output logic                            o_found_end_open,
    output logic [$clog2(MAX_RANGES+1)-1:0] o_entry_count
);

    t_dp_ctl ctl;
    t_dp_sts sts;

    // Sequence each transfer through load, walk, flush and result hand-off.
    ist_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    // Hold the table banks, evaluate one entry per walk step, drive the result.
    ist_dp #(
        .MAX_RANGES  (MAX_RANGES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (ctl),
        .o_sts              (sts),
        .i_cmd              (i_cmd),
        .i_range_start      (i_range_start),
        .i_range_end        (i_range_end),
        .i_end_open         (i_end_open),
        .o_status           (o_status),
        .o_overlap_kind     (o_overlap_kind),
        .o_overlap_position (o_overlap_position),
        .o_found_start      (o_found_start),
        .o_found_end        (o_found_end),
        .o_found_end_open   (o_found_end_open),
        .o_entry_count      (o_entry_count)
    );

endmodule

FILE: tb/sv/interval_set_table_unit_test.sv
// Self-checking testbench for the interval set table unit with a scoreboard class.
`timescale 1ns / 1ps

module interval_set_table_unit_test import ist_pkg::*;;

    localparam int unsigned DEPTH      = DEF_MAX_RANGES;
    localparam int unsigned OFS_W      = DEF_OFFSET_BITS;
    localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
    localparam logic [OFS_W-1:0] TOP   = {OFS_W{1'b1}};
    localparam int unsigned CYCLE_CAP  = 1_000_000;

    // One result as the unit presents it on its output ports.
    typedef struct {
        logic [1:0]       status;
        logic [2:0]       kind;
        logic [CNT_W-1:0] pos;
        logic [OFS_W-1:0] fs;
        logic [OFS_W-1:0] fe;
        logic             fo;
        logic [CNT_W-1:0] count;
    } t_outcome;

    // Scoreboard: keeps its own copy of the range table, predicts one outcome
    // per accepted command and matches results against the oldest prediction.
    class ist_ledger;
        logic [OFS_W-1:0] lo_q [DEPTH];
        logic [OFS_W-1:0] hi_q [DEPTH];
        bit               open_q [DEPTH];
        int unsigned      held;
        t_outcome         pending [$];
        int unsigned      errors;
        int unsigned      seen;
        int unsigned      kind_hits [6];
        int unsigned      full_hits;
        int unsigned      bad_hits;

        function new();
            held   = 0;
            errors = 0;
            seen   = 0;
            full_hits = 0;
            bad_hits  = 0;
            foreach (kind_hits[k]) kind_hits[k] = 0;
        endfunction

        function void drop_at(int unsigned i);
            if (i >= held) return;
            for (int unsigned j = i; j + 1 < held; j++) begin
                lo_q[j] = lo_q[j+1];
                hi_q[j] = hi_q[j+1];
                open_q[j] = open_q[j+1];
            end
            held--;
        endfunction

        function void put_at(int unsigned i, logic [OFS_W-1:0] s, logic [OFS_W-1:0] e, bit o);
            if (held >= DEPTH || i > held) return;
            for (int unsigned j = held; j > i; j--) begin
                lo_q[j] = lo_q[j-1];
                hi_q[j] = hi_q[j-1];
                open_q[j] = open_q[j-1];
            end
            lo_q[i] = s;
            hi_q[i] = o ? '0 : e;
            open_q[i] = o;
            held++;
        endfunction

        // First entry at or after 'from' that overlaps [s, e]; 'at' gets its
        // index, or the insertion index when nothing overlaps.
        function t_kind classify(int unsigned from, logic [OFS_W-1:0] s,
                                 logic [OFS_W-1:0] e, bit eo, output int unsigned at);
            for (int unsigned i = from; i < held; i++) begin
                if (!eo && lo_q[i] > e) begin
                    at = i;
                    return KIND_NONE;
                end
                if (!open_q[i] && s > hi_q[i]) continue;
                at = i;
                if (lo_q[i] == s && open_q[i] == eo && (open_q[i] || hi_q[i] == e))
                    return KIND_EQUAL;
                if (lo_q[i] <= s && !eo && (open_q[i] || hi_q[i] >= e))
                    return KIND_CONTAINS;
                if (s <= lo_q[i] && (eo || (!open_q[i] && e >= hi_q[i])))
                    return KIND_CONTAINED;
                if (lo_q[i] < s) return KIND_STARTS_BEFORE;
                return KIND_ENDS_AFTER;
            end
            at = held;
            return KIND_NONE;
        endfunction

        function bit touches(logic [OFS_W-1:0] lo_end, bit lo_open, logic [OFS_W-1:0] hi_start);
            return lo_open || hi_start == '0 || lo_end >= hi_start - 1'b1;
        endfunction

        function void widen_end(int unsigned i, logic [OFS_W-1:0] e, bit o);
            if (open_q[i]) return;
            if (o) begin
                open_q[i] = 1'b1;
                hi_q[i] = '0;
            end else if (e > hi_q[i]) begin
                hi_q[i] = e;
            end
        endfunction

        function void merge_forward(int unsigned i);
            while (i + 1 < held) begin
                if (!touches(hi_q[i], open_q[i], lo_q[i+1])) return;
                widen_end(i, hi_q[i+1], open_q[i+1]);
                drop_at(i + 1);
            end
        endfunction

        function void merge_backward(int unsigned i);
            while (i > 0 && i < held) begin
                if (!touches(hi_q[i-1], open_q[i-1], lo_q[i])) return;
                if (lo_q[i-1] < lo_q[i]) lo_q[i] = lo_q[i-1];
                widen_end(i, hi_q[i-1], open_q[i-1]);
                drop_at(i - 1);
                i = i - 1;
            end
        endfunction

        function t_status add_range(logic [OFS_W-1:0] s, logic [OFS_W-1:0] e, bit eo);
            int unsigned at;
            t_kind k;
            k = classify(0, s, e, eo, at);
            case (k)
                KIND_NONE: begin
                    if (held >= DEPTH) return STAT_FULL;
                    put_at(at, s, e, eo);
                    merge_forward(at);
                    merge_backward(at);
                end
                KIND_CONTAINED: begin
                    lo_q[at] = s;
                    hi_q[at] = eo ? '0 : e;
                    open_q[at] = eo;
                    merge_forward(at);
                    merge_backward(at);
                end
                KIND_STARTS_BEFORE: begin
                    widen_end(at, e, eo);
                    merge_forward(at);
                end
                KIND_ENDS_AFTER: begin
                    if (s < lo_q[at]) lo_q[at] = s;
                    merge_backward(at);
                end
                default: ;
            endcase
            return STAT_DONE;
        endfunction

        function t_status remove_range(logic [OFS_W-1:0] s, logic [OFS_W-1:0] e, bit eo);
            int unsigned from;
            int unsigned at;
            t_kind k;
            from = 0;
            for (int unsigned guard = 0; guard <= DEPTH; guard++) begin
                k = classify(from, s, e, eo, at);
                case (k)
                    KIND_NONE: return STAT_DONE;
                    KIND_EQUAL: begin
                        drop_at(at);
                        return STAT_DONE;
                    end
                    KIND_CONTAINS: begin
                        if (lo_q[at] == s) begin
                            if (e == TOP) drop_at(at);
                            else lo_q[at] = e + 1'b1;
                            return STAT_DONE;
                        end
                        if (!open_q[at] && hi_q[at] == e) begin
                            hi_q[at] = s - 1'b1;
                            return STAT_DONE;
                        end
                        // Nothing above the top offset: trim, no tail to keep.
                        if (e == TOP) begin
                            hi_q[at] = s - 1'b1;
                            open_q[at] = 1'b0;
                            return STAT_DONE;
                        end
                        if (held >= DEPTH) return STAT_FULL;
                        put_at(at + 1, e + 1'b1, hi_q[at], open_q[at]);
                        hi_q[at] = s - 1'b1;
                        open_q[at] = 1'b0;
                        return STAT_DONE;
                    end
                    KIND_CONTAINED: begin
                        drop_at(at);
                        if (at >= held) return STAT_DONE;
                        from = at;
                    end
                    KIND_STARTS_BEFORE: begin
                        hi_q[at] = s - 1'b1;
                        open_q[at] = 1'b0;
                        from = at + 1;
                        if (from >= held) return STAT_DONE;
                    end
                    default: begin
                        if (e == TOP) drop_at(at);
                        else lo_q[at] = e + 1'b1;
                        return STAT_DONE;
                    end
                endcase
            end
            return STAT_DONE;
        endfunction

        // Note one accepted command: update the table copy, queue its outcome.
        function void note_command(t_cmd c, logic [OFS_W-1:0] s, logic [OFS_W-1:0] e, bit eo);
            t_outcome o;
            int unsigned at;
            t_kind k;
            o = '{default: '0};
            if (c == CMD_CLEAR) begin
                held = 0;
            end else if (!eo && e < s) begin
                o.status = STAT_BAD_RANGE;
                bad_hits++;
            end else if (c == CMD_ADD) begin
                o.status = add_range(s, e, eo);
            end else if (c == CMD_REMOVE) begin
                o.status = remove_range(s, e, eo);
            end else begin
                k = classify(0, s, e, eo, at);
                o.kind = k;
                o.pos = CNT_W'(at);
                kind_hits[k]++;
                if (k != KIND_NONE && at < held) begin
                    o.fs = lo_q[at];
                    o.fo = open_q[at];
                    o.fe = open_q[at] ? '0 : hi_q[at];
                end
            end
            if (o.status == STAT_FULL) full_hits++;
            o.count = CNT_W'(held);
            pending.push_back(o);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Check one transferred result against the oldest prediction.
        function void check_result(t_outcome got);
            t_outcome want;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing predicted, status %0d", $time, got.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            seen++;
            compare_field("status", want.status, got.status);
            compare_field("overlap_kind", want.kind, got.kind);
            compare_field("overlap_position", want.pos, got.pos);
            compare_field("found_start", want.fs, got.fs);
            compare_field("found_end", want.fe, got.fe);
            compare_field("found_end_open", want.fo, got.fo);
            compare_field("entry_count", want.count, got.count);
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [1:0]       cmd = CMD_CLEAR;
    logic [OFS_W-1:0] range_start = '0;
    logic [OFS_W-1:0] range_end = '0;
    logic             end_open = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [1:0]       status;
    logic [2:0]       overlap_kind;
    logic [CNT_W-1:0] overlap_position;
    logic [OFS_W-1:0] found_start;
    logic [OFS_W-1:0] found_end;
    logic             found_end_open;
    logic [CNT_W-1:0] entry_count;

    int unsigned idle_pct = 0;      // chance per cycle that the sender holds off
    int unsigned stall_pct = 0;     // chance per cycle that the receiver stalls
    logic        hold_request = 1'b0;
    logic        hold_taken = 1'b0;
    int unsigned hold_left = 0;
    int unsigned cycles = 0;

    ist_ledger ledger = new();

    interval_set_table_unit dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_cmd              (cmd),
        .i_range_start      (range_start),
        .i_range_end        (range_end),
        .i_end_open         (end_open),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_status           (status),
        .o_overlap_kind     (overlap_kind),
        .o_overlap_position (overlap_position),
        .o_found_start      (found_start),
        .o_found_end        (found_end),
        .o_found_end_open   (found_end_open),
        .o_entry_count      (entry_count)
    );

    always #2 clk = ~clk;

    // Watchdog: end the run if the unit stops making progress.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("interval_set_table_unit_test: errors");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request so the unit
    // backs up and stalls its input while the sender keeps offering.
    always @(posedge clk) begin
        if (hold_request && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= 400;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Check every result transfer at the edge where it happens.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            ledger.check_result('{status, overlap_kind, overlap_position, found_start,
                                  found_end, found_end_open, entry_count});
    end

    // Offer one command; hold it until transferred, then record it.
    task automatic send(t_cmd c, logic [OFS_W-1:0] s, logic [OFS_W-1:0] e, logic eo);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        range_start <= s;
        range_end <= e;
        end_open <= eo;
        do @(posedge clk); while (in_stall);
        ledger.note_command(c, s, e, eo);
    endtask

    // Offsets cluster low so ranges overlap; a few sit at the top of the
    // space or take every bit at random.
    function automatic logic [OFS_W-1:0] pick_offset(bit spaced);
        int unsigned r;
        r = $urandom_range(99);
        if (spaced) return OFS_W'($urandom_range(0, 40) * 12);
        if (r < 78) return OFS_W'($urandom_range(0, 300));
        if (r < 86) return TOP - OFS_W'($urandom_range(0, 6));
        if (r < 92) return OFS_W'($urandom_range(0, 3));
        return OFS_W'({$urandom, $urandom});
    endfunction

    task automatic send_random(bit spaced);
        int unsigned r;
        t_cmd c;
        logic [OFS_W-1:0] s;
        logic [OFS_W-1:0] e;
        logic eo;
        r = $urandom_range(99);
        if (r < 42) c = CMD_ADD;
        else if (r < 67) c = CMD_REMOVE;
        else if (r < 95) c = CMD_SCAN;
        else c = CMD_CLEAR;
        s = pick_offset(spaced);
        r = $urandom_range(99);
        if (r < 80) e = s + OFS_W'(spaced ? $urandom_range(0, 5) : $urandom_range(0, 40));
        else if (r < 90) e = pick_offset(1'b0);
        else e = OFS_W'({$urandom, $urandom});
        eo = ($urandom_range(99) < 12);
        send(c, s, e, eo);
    endtask

    task automatic run_phase(int unsigned sender_idle, int unsigned recv_stall, int unsigned n);
        idle_pct = sender_idle;
        stall_pct = recv_stall;
        for (int unsigned i = 0; i < n; i++)
            send_random((i / 60) % 3 == 1);
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fill the table with spaced ranges, then overflow it.
        for (int unsigned i = 0; i <= DEPTH; i++)
            send(CMD_ADD, OFS_W'(i * 10), OFS_W'(i * 10 + 3), 1'b0);
        send(CMD_REMOVE, 12, 12, 1'b0);           // split while full: dropped
        send(CMD_SCAN, 20, 23, 1'b0);             // equal
        send(CMD_SCAN, 21, 22, 1'b0);             // entry contains
        send(CMD_SCAN, 29, 45, 1'b0);             // entry contained
        send(CMD_SCAN, 32, 35, 1'b0);             // starts before
        send(CMD_SCAN, 28, 31, 1'b0);             // ends after
        send(CMD_SCAN, 5, 6, 1'b0);               // none, insertion point
        send(CMD_ADD, 9, 3, 1'b0);                // end below start
        send(CMD_SCAN, TOP, 0, 1'b0);
        send(CMD_CLEAR, TOP, 0, 1'b0);            // clear ignores the range
        send(CMD_ADD, TOP - 2, 0, 1'b1);          // open at the top
        send(CMD_REMOVE, TOP - 5, TOP, 1'b0);     // no tail above the top
        send(CMD_ADD, 5, 9, 1'b0);
        send(CMD_ADD, 10, 20, 1'b0);              // adjacent: coalesce
        send(CMD_ADD, 0, 0, 1'b1);                // swallow all, open
        send(CMD_REMOVE, 7, TOP, 1'b0);
        send(CMD_SCAN, 3, TOP, 1'b1);
        send(CMD_CLEAR, 0, 0, 1'b0);

        // Random phases with different idling mixes.
        run_phase(0, 0, 250);
        run_phase(87, 0, 200);
        run_phase(0, 87, 200);
        run_phase(7, 7, 250);
        hold_request <= 1'b1;
        run_phase(0, 0, 40);
        run_phase(0, 0, 110);
        in_valid <= 1'b0;

        while (ledger.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Checked %0d results: %0d table-full drops, %0d bad ranges rejected.",
                 ledger.seen, ledger.full_hits, ledger.bad_hits);
        $display("Scan classes none/equal/contains/contained/before/after: %0d %0d %0d %0d %0d %0d",
                 ledger.kind_hits[0], ledger.kind_hits[1], ledger.kind_hits[2],
                 ledger.kind_hits[3], ledger.kind_hits[4], ledger.kind_hits[5]);
        if (ledger.errors == 0 && ledger.pending.size() == 0)
            $display("interval_set_table_unit_test: clean");
        else
            $display("interval_set_table_unit_test: errors");
        $finish;
    end

endmodule
